@@ rtl/core/prag_pkg.sv @@
// ============================================================================
// prag_pkg
// Shared types and constants for the pyramid region row address generator.
// ============================================================================
package prag_pkg;

    localparam int unsigned IMG_W    = 13;
    localparam int unsigned REG_W    = 7;
    localparam int unsigned Q_W      = 18;
    localparam int unsigned ADDR_W   = 25;
    localparam int unsigned ROW_W    = 6;
    localparam int unsigned LEVEL_W  = 3;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [REG_W-1:0]   MAX_REGION = 7'd64;
    localparam logic [LEVEL_W:0]   MAX_LEVELS = 4'd8;

    localparam logic [IMG_W-1:0] RST_IMAGE_COLS  = 13'd640;
    localparam logic [IMG_W-1:0] RST_IMAGE_ROWS  = 13'd480;
    localparam logic [REG_W-1:0] RST_REGION_COLS = 7'd32;
    localparam logic [REG_W-1:0] RST_WIN_ROWS    = 7'd32;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_COLS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_ROWS    = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_BASE,
        ST_PLACE_X,
        ST_PLACE_Y,
        ST_MUL,
        ST_ADD,
        ST_EMIT,
        ST_FAIL
    } state_t;

endpackage

@@ rtl/core/prag_place.sv @@
// ============================================================================
// prag_place
// Window placement for one axis: offset of a window centred on floor(centre)
// and pulled back inside the level, plus the centre relative to the window.
// ============================================================================
module prag_place (
    input  logic signed [prag_pkg::Q_W-1:0]   center,
    input  logic        [prag_pkg::REG_W-1:0] size,
    input  logic        [prag_pkg::IMG_W-1:0] dim,
    output logic        [prag_pkg::IMG_W-1:0] offset,
    output logic signed [prag_pkg::Q_W-1:0]   rel_center
);

    logic signed [15:0] c_int;
    logic signed [15:0] half;
    logic signed [15:0] dim_s;
    logic signed [15:0] lo;
    logic signed [15:0] hi;
    logic signed [15:0] off;
    logic signed [19:0] rel;

    assign c_int = {{2{center[17]}}, center[17:4]};
    assign half  = {10'b0, size[6:1]};
    assign dim_s = {3'b0, dim};
    assign lo    = c_int - half;
    assign hi    = c_int + half;

    always_comb
    begin
        priority if (lo < 16'sd0)
        begin
            off = 16'sd0;
        end
        else if (hi > dim_s)
        begin
            off = dim_s - {9'b0, size};
        end
        else
        begin
            off = lo;
        end
    end

    assign offset = off[12:0];
    assign rel    = {{2{center[17]}}, center} - {3'b0, offset, 4'b0};

    always_comb
    begin
        priority if (rel > 20'sd131071)
        begin
            rel_center = 18'sh1FFFF;
        end
        else if (rel < -20'sd131072)
        begin
            rel_center = 18'sh20000;
        end
        else
        begin
            rel_center = rel[17:0];
        end
    end

endmodule

@@ rtl/core/pyramid_region_row_address_gen_core.sv @@
// ============================================================================
// pyramid_region_row_address_gen_core
// Region row address generator: one request in, one beat per region row out.
// ============================================================================
// A request (level, Q.4 centre) is taken only while the block is idle. The
// sequencer then runs the checks, one level step per lower level summing the
// level areas through the shared accumulator, window placement (x then y
// through one placement unit), a multiply step and an add step, and then
// emits one beat per window row, one per cycle while out_stall is low. A
// request holds off the input until its last row beat is loaded; a failing
// request passes from the check state to the fail state and gives a single
// beat there.
// Configuration is always ready and must only be written while idle.
module pyramid_region_row_address_gen_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic        [prag_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic        [prag_pkg::IMG_W-1:0]     cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic        [prag_pkg::LEVEL_W-1:0]   level,
    input  logic signed [prag_pkg::Q_W-1:0]       center_x,
    input  logic signed [prag_pkg::Q_W-1:0]       center_y,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic                                  status,
    output logic        [prag_pkg::ADDR_W-1:0]    row_address,
    output logic        [prag_pkg::ROW_W-1:0]     row_index,
    output logic signed [prag_pkg::Q_W-1:0]       region_center_x,
    output logic signed [prag_pkg::Q_W-1:0]       region_center_y,
    output logic                                  last
);

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_CLEAR,
        ACC_MUL,
        ACC_OX,
        ACC_COL
    } acc_sel_t;

    prag_pkg::state_t state_reg, state_next;

    logic [prag_pkg::IMG_W-1:0] image_cols_reg, image_rows_reg;
    logic [prag_pkg::REG_W-1:0] region_cols_reg, win_rows_reg;

    logic [prag_pkg::LEVEL_W-1:0]   level_reg;
    logic [prag_pkg::LEVEL_W-1:0]   lvl_cnt_reg, lvl_cnt_next;
    logic signed [prag_pkg::Q_W-1:0] cx_reg, cy_reg;
    logic [prag_pkg::IMG_W-1:0]     lc_reg, lr_reg;
    logic [2*prag_pkg::IMG_W-1:0]   mul_reg;
    logic [prag_pkg::ADDR_W-1:0]    acc_reg;
    logic [prag_pkg::IMG_W-1:0]     ox_reg, oy_reg;
    logic signed [prag_pkg::Q_W-1:0] rcx_reg, rcy_reg;
    logic [prag_pkg::ROW_W-1:0]     row_cnt_reg;

    logic                           out_valid_reg;
    logic                           status_reg;
    logic [prag_pkg::ADDR_W-1:0]    row_address_reg;
    logic [prag_pkg::ROW_W-1:0]     row_index_reg;
    logic signed [prag_pkg::Q_W-1:0] region_center_x_reg, region_center_y_reg;
    logic                           last_reg;

    logic                           in_accept;
    logic                           out_free;
    logic                           fail;
    logic                           last_row;

    acc_sel_t                       acc_sel;
    logic                           mul_load_area;
    logic                           mul_load_row;
    logic                           mul_shift;
    logic                           place_x_load;
    logic                           place_y_load;
    logic                           row_step;
    logic                           out_load_row;
    logic                           out_load_fail;

    logic [prag_pkg::ADDR_W-1:0]    addend;
    logic [prag_pkg::IMG_W-1:0]     mul_a, mul_b;

    logic signed [prag_pkg::Q_W-1:0] pl_center;
    logic [prag_pkg::REG_W-1:0]      pl_size;
    logic [prag_pkg::IMG_W-1:0]      pl_dim;
    logic [prag_pkg::IMG_W-1:0]      pl_offset;
    logic signed [prag_pkg::Q_W-1:0] pl_rel;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != prag_pkg::ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign last_row  = ({1'b0, row_cnt_reg} + 7'd1) == win_rows_reg;

    assign fail = ({1'b0, level_reg} >= prag_pkg::MAX_LEVELS)
               || ({6'b0, region_cols_reg} > lc_reg)
               || ({6'b0, win_rows_reg} > lr_reg)
               || region_cols_reg[0] || win_rows_reg[0]
               || (region_cols_reg == 7'd0) || (win_rows_reg == 7'd0)
               || (region_cols_reg > prag_pkg::MAX_REGION)
               || (win_rows_reg > prag_pkg::MAX_REGION);

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_cols_reg  <= prag_pkg::RST_IMAGE_COLS;
            image_rows_reg  <= prag_pkg::RST_IMAGE_ROWS;
            region_cols_reg <= prag_pkg::RST_REGION_COLS;
            win_rows_reg    <= prag_pkg::RST_WIN_ROWS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                prag_pkg::CFG_IMAGE_COLS:  image_cols_reg  <= cfg_data;
                prag_pkg::CFG_IMAGE_ROWS:  image_rows_reg  <= cfg_data;
                prag_pkg::CFG_REGION_COLS: region_cols_reg <= cfg_data[6:0];
                prag_pkg::CFG_WIN_ROWS:    win_rows_reg    <= cfg_data[6:0];
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            prag_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = prag_pkg::ST_CHECK;
                end
            end
            prag_pkg::ST_CHECK:
            begin
                priority if (fail)
                begin
                    state_next = prag_pkg::ST_FAIL;
                end
                else if (level_reg == 3'd0)
                begin
                    state_next = prag_pkg::ST_PLACE_X;
                end
                else
                begin
                    state_next = prag_pkg::ST_BASE;
                end
            end
            prag_pkg::ST_BASE:
            begin
                if (lvl_cnt_reg == 3'd1)
                begin
                    state_next = prag_pkg::ST_PLACE_X;
                end
            end
            prag_pkg::ST_PLACE_X: state_next = prag_pkg::ST_PLACE_Y;
            prag_pkg::ST_PLACE_Y: state_next = prag_pkg::ST_MUL;
            prag_pkg::ST_MUL:     state_next = prag_pkg::ST_ADD;
            prag_pkg::ST_ADD:     state_next = prag_pkg::ST_EMIT;
            prag_pkg::ST_EMIT:
            begin
                if (out_free && last_row)
                begin
                    state_next = prag_pkg::ST_IDLE;
                end
            end
            prag_pkg::ST_FAIL:
            begin
                if (out_free)
                begin
                    state_next = prag_pkg::ST_IDLE;
                end
            end
            default: state_next = prag_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        acc_sel       = ACC_HOLD;
        mul_load_area = 1'b0;
        mul_load_row  = 1'b0;
        mul_shift     = 1'b0;
        place_x_load  = 1'b0;
        place_y_load  = 1'b0;
        row_step      = 1'b0;
        out_load_row  = 1'b0;
        out_load_fail = 1'b0;
        unique case (state_reg)
            prag_pkg::ST_IDLE: ;
            prag_pkg::ST_CHECK:
            begin
                acc_sel       = ACC_CLEAR;
                mul_load_area = 1'b1;
            end
            prag_pkg::ST_BASE:
            begin
                acc_sel   = ACC_MUL;
                mul_shift = 1'b1;
            end
            prag_pkg::ST_PLACE_X:
            begin
                place_x_load = 1'b1;
            end
            prag_pkg::ST_PLACE_Y:
            begin
                place_y_load = 1'b1;
                acc_sel      = ACC_OX;
            end
            prag_pkg::ST_MUL:
            begin
                mul_load_row = 1'b1;
            end
            prag_pkg::ST_ADD:
            begin
                acc_sel = ACC_MUL;
            end
            prag_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_load_row = 1'b1;
                    row_step     = 1'b1;
                    acc_sel      = ACC_COL;
                end
            end
            prag_pkg::ST_FAIL:
            begin
                out_load_fail = out_free;
            end
            default: ;
        endcase
    end

    // shared placement unit
    always_comb
    begin
        if (state_reg == prag_pkg::ST_PLACE_Y)
        begin
            pl_center = cy_reg;
            pl_size   = win_rows_reg;
            pl_dim    = lr_reg;
        end
        else
        begin
            pl_center = cx_reg;
            pl_size   = region_cols_reg;
            pl_dim    = lc_reg;
        end
    end

    prag_place u_place (
        .center     (pl_center),
        .size       (pl_size),
        .dim        (pl_dim),
        .offset     (pl_offset),
        .rel_center (pl_rel)
    );

    // shared multiplier and accumulator operands
    assign mul_a = mul_load_row ? oy_reg : image_cols_reg;
    assign mul_b = mul_load_row ? lc_reg : image_rows_reg;

    always_comb
    begin
        unique case (acc_sel)
            ACC_MUL: addend = mul_reg[prag_pkg::ADDR_W-1:0];
            ACC_OX:  addend = {12'b0, ox_reg};
            ACC_COL: addend = {12'b0, lc_reg};
            default: addend = '0;
        endcase
    end

    assign lvl_cnt_next = lvl_cnt_reg - 3'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= prag_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load_row || out_load_fail)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            level_reg   <= level;
            lvl_cnt_reg <= level;
            cx_reg      <= center_x;
            cy_reg      <= center_y;
            lc_reg      <= image_cols_reg >> level;
            lr_reg      <= image_rows_reg >> level;
            row_cnt_reg <= '0;
        end
        else if (row_step)
        begin
            row_cnt_reg <= row_cnt_reg + 6'd1;
        end
        if (mul_shift)
        begin
            lvl_cnt_reg <= lvl_cnt_next;
        end

        if (mul_load_area || mul_load_row)
        begin
            mul_reg <= mul_a * mul_b;
        end
        else if (mul_shift)
        begin
            mul_reg <= mul_reg >> 2;
        end

        if (acc_sel == ACC_CLEAR)
        begin
            acc_reg <= '0;
        end
        else if (acc_sel != ACC_HOLD)
        begin
            acc_reg <= acc_reg + addend;
        end

        if (place_x_load)
        begin
            ox_reg  <= pl_offset;
            rcx_reg <= pl_rel;
        end
        if (place_y_load)
        begin
            oy_reg  <= pl_offset;
            rcy_reg <= pl_rel;
        end

        if (out_load_row)
        begin
            status_reg          <= 1'b0;
            row_address_reg     <= acc_reg;
            row_index_reg       <= row_cnt_reg;
            region_center_x_reg <= rcx_reg;
            region_center_y_reg <= rcy_reg;
            last_reg            <= last_row;
        end
        else if (out_load_fail)
        begin
            status_reg          <= 1'b1;
            row_address_reg     <= '0;
            row_index_reg       <= '0;
            region_center_x_reg <= '0;
            region_center_y_reg <= '0;
            last_reg            <= 1'b1;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign row_address     = row_address_reg;
    assign row_index       = row_index_reg;
    assign region_center_x = region_center_x_reg;
    assign region_center_y = region_center_y_reg;
    assign last            = last_reg;

`ifndef ASSERT_OFF
    a_fail_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg) |-> (last_reg && row_address_reg == '0
            && row_index_reg == '0))
        else $error("failure beat not terminal or not cleared");

    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !status_reg)
            |-> (last_reg == (({1'b0, row_index_reg} + 7'd1) == win_rows_reg)))
        else $error("last flag does not match row index");

    a_window_x: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == prag_pkg::ST_EMIT)
            |-> (({1'b0, ox_reg} + {7'b0, region_cols_reg}) <= {1'b0, lc_reg}))
        else $error("window x outside level");

    a_window_y: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == prag_pkg::ST_EMIT)
            |-> (({1'b0, oy_reg} + {7'b0, win_rows_reg}) <= {1'b0, lr_reg}))
        else $error("window y outside level");

    a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == prag_pkg::ST_CHECK))
        else $error("accepted beat not started");
`endif

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for pyramid_region_row_address_gen_core.
// ----------------------------------------------------------------------------
// A directed table covers the reset setup, centre extremes, the top level and
// failing window sizes. Random phases with fresh image and window sizes
// follow. Each accepted request is expanded into the row beats it should
// produce, and every output beat is compared in order. Both sides idle in
// random bursts, and the last phase runs at full rate.
// ============================================================================
module tb_top;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_REQS     = 32;

    typedef enum logic [1:0] {
        STEP_CFG,
        STEP_PRED,
        STEP_FAIL,
        STEP_ORIGIN
    } step_t;

    typedef struct {
        step_t                           step;
        logic [prag_pkg::CFG_IDX_W-1:0]  idx;
        logic [prag_pkg::IMG_W-1:0]      data;
        logic [prag_pkg::LEVEL_W-1:0]    lvl;
        logic signed [prag_pkg::Q_W-1:0] cx;
        logic signed [prag_pkg::Q_W-1:0] cy;
    } plan_row_t;

    typedef struct {
        logic                            status;
        logic [prag_pkg::ADDR_W-1:0]     row_address;
        logic [prag_pkg::ROW_W-1:0]      row_index;
        logic signed [prag_pkg::Q_W-1:0] center_x;
        logic signed [prag_pkg::Q_W-1:0] center_y;
        logic                            last;
    } row_beat_t;

    logic                                clk;
    logic                                rst_n;
    logic                                cfg_valid;
    logic                                cfg_ready;
    logic [prag_pkg::CFG_IDX_W-1:0]      cfg_index;
    logic [prag_pkg::IMG_W-1:0]          cfg_data;
    logic                                in_valid;
    logic                                in_stall;
    logic [prag_pkg::LEVEL_W-1:0]        level;
    logic signed [prag_pkg::Q_W-1:0]     center_x;
    logic signed [prag_pkg::Q_W-1:0]     center_y;
    logic                                out_valid;
    logic                                out_stall;
    logic                                status;
    logic [prag_pkg::ADDR_W-1:0]         row_address;
    logic [prag_pkg::ROW_W-1:0]          row_index;
    logic signed [prag_pkg::Q_W-1:0]     region_center_x;
    logic signed [prag_pkg::Q_W-1:0]     region_center_y;
    logic                                last;

    // register shadow
    logic [prag_pkg::IMG_W-1:0]          img_cols;
    logic [prag_pkg::IMG_W-1:0]          img_rows;
    logic [prag_pkg::REG_W-1:0]          win_cols;
    logic [prag_pkg::REG_W-1:0]          win_rows;

    row_beat_t                   row_beats_due[$];
    row_beat_t                   due;
    plan_row_t                   plan[$];

    int                          mismatches;
    int                          req_count;
    int                          beat_count;
    int                          fail_beats;
    int                          settings_count;
    int                          stuck_cycles;
    int                          gap_pct;
    int                          stall_pct;
    int                          stall_burst;
    bit                          no_idling;

    pyramid_region_row_address_gen_core u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .level           (level),
        .center_x        (center_x),
        .center_y        (center_y),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .row_address     (row_address),
        .row_index       (row_index),
        .region_center_x (region_center_x),
        .region_center_y (region_center_y),
        .last            (last)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic row_beat_t fail_beat();
        row_beat_t b;
        b.status      = 1'b1;
        b.row_address = '0;
        b.row_index   = '0;
        b.center_x    = '0;
        b.center_y    = '0;
        b.last        = 1'b1;
        return b;
    endfunction

    function automatic longint place_window(input longint c, input longint h,
                                            input longint dim);
        longint off;
        off = c - h;
        if (c + h > dim)
            off -= (c + h) - dim;
        if (c - h < 0)
            off = 0;
        return off;
    endfunction

    function automatic logic signed [prag_pkg::Q_W-1:0] sat_q4(input longint v);
        if (v > 131071)
            v = 131071;
        if (v < -131072)
            v = -131072;
        return v[prag_pkg::Q_W-1:0];
    endfunction

    task automatic predict_rows(input logic [prag_pkg::LEVEL_W-1:0] lvl,
                                input logic signed [prag_pkg::Q_W-1:0] cx,
                                input logic signed [prag_pkg::Q_W-1:0] cy);
        logic [prag_pkg::IMG_W-1:0] lc;
        logic [prag_pkg::IMG_W-1:0] lr;
        longint unsigned  area;
        longint unsigned  base;
        longint           ox;
        longint           oy;
        longint           addr;
        row_beat_t        b;
        lc = img_cols >> lvl;
        lr = img_rows >> lvl;
        if (({1'b0, lvl} >= prag_pkg::MAX_LEVELS) || (win_cols > lc) ||
            (win_rows > lr) || win_cols[0] || win_rows[0] || (win_cols == 0) ||
            (win_rows == 0) || (win_cols > prag_pkg::MAX_REGION) ||
            (win_rows > prag_pkg::MAX_REGION))
        begin
            row_beats_due.push_back(fail_beat());
        end
        else
        begin
            area = longint'(img_cols) * longint'(img_rows);
            base = 0;
            for (int l = 0; l < lvl; l++)
                base += area >> (2 * l);
            ox = place_window(longint'(cx) >>> 4, longint'(win_cols / 2), longint'(lc));
            oy = place_window(longint'(cy) >>> 4, longint'(win_rows / 2), longint'(lr));
            for (int y = 0; y < win_rows; y++)
            begin
                addr          = longint'(base) + (oy + y) * longint'(lc) + ox;
                b.status      = 1'b0;
                b.row_address = addr[prag_pkg::ADDR_W-1:0];
                b.row_index   = y[prag_pkg::ROW_W-1:0];
                b.center_x    = sat_q4(longint'(cx) - 16 * ox);
                b.center_y    = sat_q4(longint'(cy) - 16 * oy);
                b.last        = (y + 1 == win_rows);
                row_beats_due.push_back(b);
            end
        end
    endtask

    task automatic cfg_write(input logic [prag_pkg::CFG_IDX_W-1:0] idx,
                             input logic [prag_pkg::IMG_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            prag_pkg::CFG_IMAGE_COLS:  img_cols = data;
            prag_pkg::CFG_IMAGE_ROWS:  img_rows = data;
            prag_pkg::CFG_REGION_COLS: win_cols = data[prag_pkg::REG_W-1:0];
            prag_pkg::CFG_WIN_ROWS:    win_rows = data[prag_pkg::REG_W-1:0];
            default: ;
        endcase
        settings_count++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_request(input step_t step,
                                input logic [prag_pkg::LEVEL_W-1:0] lvl,
                                input logic signed [prag_pkg::Q_W-1:0] cx,
                                input logic signed [prag_pkg::Q_W-1:0] cy);
        row_beat_t b;
        int        n;
        if (!no_idling && $urandom_range(0, 99) < gap_pct)
        begin
            n = $urandom_range(1, 18);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        level    <= lvl;
        center_x <= cx;
        center_y <= cy;
        do
            @(posedge clk);
        while (in_stall);
        req_count++;
        case (step)
            STEP_FAIL:
                row_beats_due.push_back(fail_beat());
            STEP_ORIGIN:
                for (int y = 0; y < win_rows; y++)
                begin
                    b.status      = 1'b0;
                    b.row_address = prag_pkg::ADDR_W'(y * img_cols);
                    b.row_index   = y[prag_pkg::ROW_W-1:0];
                    b.center_x    = cx;
                    b.center_y    = cy;
                    b.last        = (y + 1 == win_rows);
                    row_beats_due.push_back(b);
                end
            default:
                predict_rows(lvl, cx, cy);
        endcase
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // block is idle once every due beat has come back
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (row_beats_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [prag_pkg::IMG_W-1:0] pick_image_size();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return prag_pkg::IMG_W'($urandom_range(64, 4096));
        else if (r < 95)
            return prag_pkg::IMG_W'($urandom_range(1, 63));
        return prag_pkg::IMG_W'($urandom_range(4097, 8191));
    endfunction

    function automatic logic [prag_pkg::REG_W-1:0] pick_region_size();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return prag_pkg::REG_W'(2 * $urandom_range(1, 8));
        else if (r < 90)
            return prag_pkg::REG_W'(2 * $urandom_range(9, 32));
        else if (r < 94)
            return prag_pkg::REG_W'(2 * $urandom_range(0, 31) + 1);
        else if (r < 96)
            return '0;
        return prag_pkg::REG_W'($urandom_range(65, 127));
    endfunction

    function automatic logic signed [prag_pkg::Q_W-1:0] pick_center(
        input logic [prag_pkg::IMG_W-1:0] dim);
        if ($urandom_range(0, 99) < 70)
            return prag_pkg::Q_W'(int'($urandom_range(0, int'(dim) * 16 + 63)) - 32);
        return prag_pkg::Q_W'($urandom());
    endfunction

    function automatic void check_field(input string name, input longint want,
                                        input longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (stuck_cycles >= WATCHDOG_LIMIT)
            begin
                $display("** pyramid_region_row_address_gen_core: FAILED **");
                $finish;
            end
            if (out_valid && !out_stall)
            begin
                beat_count++;
                if (status)
                    fail_beats++;
                if (row_beats_due.size() == 0)
                begin
                    $error("unexpected beat: row_address %0d row_index %0d",
                           row_address, row_index);
                    mismatches++;
                end
                else
                begin
                    due = row_beats_due.pop_front();
                    check_field("status", due.status, status);
                    check_field("row_address", due.row_address, row_address);
                    check_field("row_index", due.row_index, row_index);
                    check_field("region_center_x", due.center_x, region_center_x);
                    check_field("region_center_y", due.center_y, region_center_y);
                    check_field("last", due.last, last);
                end
            end
        end
    end

    initial
    begin
        out_stall   = 1'b0;
        stall_burst = 0;
        forever
        begin
            @(negedge clk);
            if (no_idling)
            begin
                stall_burst = 0;
                out_stall <= 1'b0;
            end
            else if (stall_burst > 0)
            begin
                stall_burst--;
                out_stall <= 1'b1;
            end
            else if ($urandom_range(0, 99) < stall_pct)
            begin
                stall_burst = $urandom_range(1, 18) - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin : stimulus
        logic [prag_pkg::IMG_W-1:0]   v_cols;
        logic [prag_pkg::IMG_W-1:0]   v_rows;
        logic [prag_pkg::REG_W-1:0]   v_rc;
        logic [prag_pkg::REG_W-1:0]   v_rr;
        logic [prag_pkg::LEVEL_W-1:0] lvl;
        int                           maxl;
        int                           rand_reqs;

        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        level          = '0;
        center_x       = '0;
        center_y       = '0;
        img_cols       = prag_pkg::RST_IMAGE_COLS;
        img_rows       = prag_pkg::RST_IMAGE_ROWS;
        win_cols       = prag_pkg::RST_REGION_COLS;
        win_rows       = prag_pkg::RST_WIN_ROWS;
        mismatches     = 0;
        req_count      = 0;
        beat_count     = 0;
        fail_beats     = 0;
        settings_count = 0;
        stuck_cycles   = 0;
        gap_pct        = 20;
        stall_pct      = 10;
        no_idling      = 1'b0;
        rand_reqs      = 0;

        plan = '{
            '{STEP_ORIGIN, prag_pkg::CFG_IMAGE_COLS,  13'd0,    3'd0, 18'sd0,    18'sd0},
            '{STEP_PRED,   prag_pkg::CFG_IMAGE_COLS,  13'd0,    3'd0, 18'sd5128, 18'sd3855},
            '{STEP_PRED,   prag_pkg::CFG_IMAGE_COLS,  13'd0,    3'd0, 18'h1FFFF, 18'h1FFFF},
            '{STEP_ORIGIN, prag_pkg::CFG_IMAGE_COLS,  13'd0,    3'd0, 18'h20000, 18'h20000},
            '{STEP_FAIL,   prag_pkg::CFG_IMAGE_COLS,  13'd0,    3'd7, 18'sd0,    18'sd0},
            '{STEP_FAIL,   prag_pkg::CFG_IMAGE_COLS,  13'd0,    3'd4, 18'sd320,  18'sd320},
            '{STEP_PRED,   prag_pkg::CFG_IMAGE_COLS,  13'd0,    3'd3, -18'sd1,   18'sd960},
            '{STEP_CFG,    prag_pkg::CFG_REGION_COLS, 13'd31,   3'd0, 18'sd0,    18'sd0},
            '{STEP_FAIL,   prag_pkg::CFG_IMAGE_COLS,  13'd0,    3'd0, 18'sd4000, 18'sd4000},
            '{STEP_CFG,    prag_pkg::CFG_REGION_COLS, 13'd0,    3'd0, 18'sd0,    18'sd0},
            '{STEP_FAIL,   prag_pkg::CFG_IMAGE_COLS,  13'd0,    3'd0, 18'sd4000, 18'sd4000},
            '{STEP_CFG,    prag_pkg::CFG_REGION_COLS, 13'd66,   3'd0, 18'sd0,    18'sd0},
            '{STEP_FAIL,   prag_pkg::CFG_IMAGE_COLS,  13'd0,    3'd0, 18'sd4000, 18'sd4000},
            '{STEP_CFG,    prag_pkg::CFG_IMAGE_COLS,  13'd4096, 3'd0, 18'sd0,    18'sd0},
            '{STEP_CFG,    prag_pkg::CFG_IMAGE_ROWS,  13'd4096, 3'd0, 18'sd0,    18'sd0},
            '{STEP_CFG,    prag_pkg::CFG_REGION_COLS, 13'd64,   3'd0, 18'sd0,    18'sd0},
            '{STEP_CFG,    prag_pkg::CFG_WIN_ROWS,    13'd64,   3'd0, 18'sd0,    18'sd0},
            '{STEP_PRED,   prag_pkg::CFG_IMAGE_COLS,  13'd0,    3'd6, 18'h1FFFF, 18'h20000},
            '{STEP_FAIL,   prag_pkg::CFG_IMAGE_COLS,  13'd0,    3'd7, 18'sd256,  18'sd256},
            '{STEP_CFG,    prag_pkg::CFG_IMAGE_COLS,  13'h1FFF, 3'd0, 18'sd0,    18'sd0},
            '{STEP_CFG,    prag_pkg::CFG_IMAGE_ROWS,  13'h1FFF, 3'd0, 18'sd0,    18'sd0},
            '{STEP_PRED,   prag_pkg::CFG_IMAGE_COLS,  13'd0,    3'd6, 18'sd2032, 18'sd1600},
            '{STEP_CFG,    prag_pkg::CFG_WIN_ROWS,    13'd127,  3'd0, 18'sd0,    18'sd0},
            '{STEP_FAIL,   prag_pkg::CFG_IMAGE_COLS,  13'd0,    3'd0, 18'sd0,    18'sd0},
            '{STEP_CFG,    prag_pkg::CFG_WIN_ROWS,    13'd1,    3'd0, 18'sd0,    18'sd0},
            '{STEP_FAIL,   prag_pkg::CFG_IMAGE_COLS,  13'd0,    3'd0, 18'sd0,    18'sd0},
            '{STEP_CFG,    prag_pkg::CFG_IMAGE_COLS,  13'd2,    3'd0, 18'sd0,    18'sd0},
            '{STEP_CFG,    prag_pkg::CFG_IMAGE_ROWS,  13'd2,    3'd0, 18'sd0,    18'sd0},
            '{STEP_CFG,    prag_pkg::CFG_REGION_COLS, 13'h1F82, 3'd0, 18'sd0,    18'sd0},
            '{STEP_CFG,    prag_pkg::CFG_WIN_ROWS,    13'd2,    3'd0, 18'sd0,    18'sd0},
            '{STEP_PRED,   prag_pkg::CFG_IMAGE_COLS,  13'd0,    3'd0, 18'sd16,   18'sd31},
            '{STEP_FAIL,   prag_pkg::CFG_IMAGE_COLS,  13'd0,    3'd1, 18'sd16,   18'sd16},
            '{STEP_CFG,    prag_pkg::CFG_IMAGE_COLS,  13'd1,    3'd0, 18'sd0,    18'sd0},
            '{STEP_FAIL,   prag_pkg::CFG_IMAGE_COLS,  13'd0,    3'd0, 18'sd0,    18'sd0}
        };

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].step == STEP_CFG)
            begin
                settle();
                cfg_write(plan[i].idx, plan[i].data);
            end
            else
                send_request(plan[i].step, plan[i].lvl, plan[i].cx, plan[i].cy);
        end

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            settle();
            no_idling = (p == RANDOM_PHASES - 1);
            gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
            stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(3, 20);
            v_cols = pick_image_size();
            v_rows = pick_image_size();
            v_rc   = pick_region_size();
            v_rr   = pick_region_size();
            cfg_write(prag_pkg::CFG_IMAGE_COLS, v_cols);
            cfg_write(prag_pkg::CFG_IMAGE_ROWS, v_rows);
            cfg_write(prag_pkg::CFG_REGION_COLS, prag_pkg::IMG_W'(v_rc));
            cfg_write(prag_pkg::CFG_WIN_ROWS, prag_pkg::IMG_W'(v_rr));
            maxl = -1;
            for (int l = 0; l < 8; l++)
                if (((v_cols >> l) >= v_rc) && ((v_rows >> l) >= v_rr))
                    maxl = l;
            for (int k = 0; k < PHASE_REQS; k++)
            begin
                if (maxl >= 0 && $urandom_range(0, 99) < 85)
                    lvl = prag_pkg::LEVEL_W'($urandom_range(0, maxl));
                else
                    lvl = prag_pkg::LEVEL_W'($urandom_range(0, 7));
                send_request(STEP_PRED, lvl, pick_center(v_cols >> lvl),
                             pick_center(v_rows >> lvl));
                rand_reqs++;
            end
        end

        settle();
        $display("Run covered %0d requests (%0d random) across %0d register writes,",
                 req_count, rand_reqs, settings_count);
        $display("checking %0d row beats, %0d of them window failures.",
                 beat_count, fail_beats);
        if (mismatches == 0 && row_beats_due.size() == 0)
            $display("** pyramid_region_row_address_gen_core: PASSED **");
        else
            $display("** pyramid_region_row_address_gen_core: FAILED **");
        $finish;
    end

endmodule
